[rtl/core/ata_pkg.sv]
// Shared types, constants and the arctangent table of the tilt angle pipeline.
package ata_pkg;

  localparam int DATA_W          = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ROTATION_STEPS  = 16;
  localparam int TABLE_LEN       = 24;
  localparam int CORDIC_STEPS    = (ROTATION_STEPS > TABLE_LEN) ? TABLE_LEN : ROTATION_STEPS;
  localparam int TABLE_IDX_W     = $clog2(TABLE_LEN);

  localparam int SUM_W      = 2 * DATA_W;
  localparam int ROOT_W     = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int TABLE_FRAC = 16;
  localparam int XY_W       = ROOT_W + 4;
  localparam int Z_W        = 25;
  localparam int ZC_W       = 24;

  localparam int LIM_Q16 = 90 << TABLE_FRAC;
  localparam int RND_SH  = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam int HALF    = 1 << (RND_SH - 1);
  localparam int CAP     = ((90 << ANGLE_FRAC_BITS) > 32767) ? 32767 : (90 << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [DATA_W-1:0] mag;
    logic              neg;
  } sqrt_lane_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   nz;
    logic                   den_zero;
    logic                   neg;
  } cordic_lane_t;

  // atan(2^-i) in degrees, Q.16, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_deg_q16(input logic [TABLE_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:    v = 25'sd2949120;
      5'd1:    v = 25'sd1740967;
      5'd2:    v = 25'sd919879;
      5'd3:    v = 25'sd466945;
      5'd4:    v = 25'sd234379;
      5'd5:    v = 25'sd117304;
      5'd6:    v = 25'sd58666;
      5'd7:    v = 25'sd29335;
      5'd8:    v = 25'sd14668;
      5'd9:    v = 25'sd7334;
      5'd10:   v = 25'sd3667;
      5'd11:   v = 25'sd1833;
      5'd12:   v = 25'sd917;
      5'd13:   v = 25'sd458;
      5'd14:   v = 25'sd229;
      5'd15:   v = 25'sd115;
      5'd16:   v = 25'sd57;
      5'd17:   v = 25'sd29;
      5'd18:   v = 25'sd14;
      5'd19:   v = 25'sd7;
      5'd20:   v = 25'sd4;
      5'd21:   v = 25'sd2;
      5'd22:   v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/ata_sqrt_step.sv]
// One registered digit step of the pipelined integer square root.
module ata_sqrt_step (
  input  logic                clk_i,
  input  logic                adv_i,
  input  ata_pkg::sqrt_lane_t lane_i,
  output ata_pkg::sqrt_lane_t lane_o
);

  ata_pkg::sqrt_lane_t         lane_d;
  ata_pkg::sqrt_lane_t         lane_q;
  logic [ata_pkg::REM_W+1:0]   acc;
  logic [ata_pkg::REM_W+1:0]   trial;
  logic [ata_pkg::REM_W+1:0]   diff;

  always_comb begin
    acc    = {lane_i.rem, lane_i.rad[ata_pkg::SUM_W-1 -: 2]};
    trial  = {2'b00, lane_i.root, 2'b01};
    diff   = acc - trial;
    lane_d = lane_i;
    lane_d.rad = {lane_i.rad[ata_pkg::SUM_W-3:0], 2'b00};
    if (acc >= trial) begin
      lane_d.rem  = diff[ata_pkg::REM_W-1:0];
      lane_d.root = {lane_i.root[ata_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      lane_d.rem  = acc[ata_pkg::REM_W-1:0];
      lane_d.root = {lane_i.root[ata_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

[rtl/core/ata_cordic_step.sv]
// One registered vectoring rotation of the arctangent pipeline.
module ata_cordic_step (
  input  logic                              clk_i,
  input  logic                              adv_i,
  input  logic [ata_pkg::TABLE_IDX_W-1:0]   shift_i,
  input  ata_pkg::cordic_lane_t             lane_i,
  output ata_pkg::cordic_lane_t             lane_o
);

  ata_pkg::cordic_lane_t        lane_d;
  ata_pkg::cordic_lane_t        lane_q;
  logic signed [ata_pkg::XY_W-1:0] xs;
  logic signed [ata_pkg::XY_W-1:0] ys;
  logic signed [ata_pkg::Z_W-1:0]  at;

  always_comb begin
    xs     = lane_i.x >>> shift_i;
    ys     = lane_i.y >>> shift_i;
    at     = ata_pkg::atan_deg_q16(shift_i);
    lane_d = lane_i;
    // rotate toward the x axis
    if (!lane_i.y[ata_pkg::XY_W-1]) begin
      lane_d.x = lane_i.x + ys;
      lane_d.y = lane_i.y - xs;
      lane_d.z = lane_i.z + at;
    end else begin
      lane_d.x = lane_i.x - ys;
      lane_d.y = lane_i.y + xs;
      lane_d.z = lane_i.z - at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

[rtl/core/ata_angle_out.sv]
// Clamp, round, saturate and sign one accumulated angle.
module ata_angle_out (
  input  ata_pkg::cordic_lane_t lane_i,
  output logic signed [15:0]    angle_o
);

  logic [ata_pkg::ZC_W-1:0] zc;
  logic [ata_pkg::ZC_W:0]   rnd;
  logic [ata_pkg::ZC_W:0]   shr;
  logic [15:0]              mag;

  always_comb begin
    if (lane_i.den_zero) begin
      zc = ata_pkg::ZC_W'(ata_pkg::LIM_Q16);
    end else if (lane_i.z < 0) begin
      zc = '0;
    end else if (lane_i.z > ata_pkg::Z_W'(ata_pkg::LIM_Q16)) begin
      zc = ata_pkg::ZC_W'(ata_pkg::LIM_Q16);
    end else begin
      zc = lane_i.z[ata_pkg::ZC_W-1:0];
    end
    rnd = {1'b0, zc} + (ata_pkg::ZC_W+1)'(ata_pkg::HALF);
    shr = rnd >> ata_pkg::RND_SH;
    if (shr > (ata_pkg::ZC_W+1)'(ata_pkg::CAP)) begin
      mag = 16'(ata_pkg::CAP);
    end else begin
      mag = shr[15:0];
    end
    if (!lane_i.nz) begin
      angle_o = '0;
    end else if (lane_i.neg) begin
      angle_o = -$signed(mag);
    end else begin
      angle_o = $signed(mag);
    end
  end

endmodule

[rtl/core/accel_tilt_angles_core.sv]
// Top level of the accelerometer roll and pitch pipeline.
//
// Takes one signed three-axis sample per unstalled cycle and returns roll =
// atan(y / sqrt(x^2+z^2)) and pitch = atan(-x / sqrt(y^2+z^2)) in signed
// Q7.8 degrees, saturated at +/-90. A zero divisor gives +/-90 with the
// sign of the numerator; a zero numerator gives 0; an all-zero sample gives
// 0 for both angles with all_zero_o set. Throughput is one request per
// cycle while the output is not stalled. The pipeline holds one stage
// of squares, one stage per root bit of the 32-bit square root, one
// stage per rotation, and the output register.
// The whole pipeline advances together whenever the output register is
// empty or being drained, so a stalled consumer holds every stage in place.
module accel_tilt_angles_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_deg_o,
  output logic signed [15:0] pitch_deg_o,
  output logic               all_zero_o
);

  localparam int TOT = ata_pkg::SQRT_STEPS + ata_pkg::CORDIC_STEPS;

  logic adv;

  // valid and all-zero flags march alongside the data
  logic [TOT:0] pipe_vld_q;
  logic [TOT:0] pipe_zero_q;

  // square stage
  logic signed [15:0]            ax_q, ay_q;
  logic [ata_pkg::SUM_W-1:0]     ax2_q, ay2_q, az2_q;
  logic signed [31:0]            ax2, ay2, az2;

  ata_pkg::sqrt_lane_t   sq_lane [0:ata_pkg::SQRT_STEPS][2];
  ata_pkg::cordic_lane_t cd_lane [0:ata_pkg::CORDIC_STEPS][2];

  logic signed [15:0] roll_d, pitch_d;
  logic signed [15:0] roll_q, pitch_q;
  logic               zero_q, out_valid_q;

  // advance everything when the output slot is free or being taken
  assign adv        = out_ready_i | ~out_valid_q;
  assign in_ready_o = adv;

  assign ax2 = accel_x_i * accel_x_i;
  assign ay2 = accel_y_i * accel_y_i;
  assign az2 = accel_z_i * accel_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q <= '0;
    end else if (adv) begin
      pipe_vld_q <= {pipe_vld_q[TOT-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_zero_q <= {pipe_zero_q[TOT-1:0],
                      (accel_x_i == 16'sd0) && (accel_y_i == 16'sd0) && (accel_z_i == 16'sd0)};
      ax_q  <= accel_x_i;
      ay_q  <= accel_y_i;
      ax2_q <= ax2;
      ay2_q <= ay2;
      az2_q <= az2;
    end
  end

  // seed the root lanes: roll takes y over xz, pitch takes -x over yz
  always_comb begin
    sq_lane[0][0].rad  = ax2_q + az2_q;
    sq_lane[0][0].rem  = '0;
    sq_lane[0][0].root = '0;
    sq_lane[0][0].mag  = ay_q[15] ? 16'(-ay_q) : ay_q;
    sq_lane[0][0].neg  = ay_q[15];
    sq_lane[0][1].rad  = ay2_q + az2_q;
    sq_lane[0][1].rem  = '0;
    sq_lane[0][1].root = '0;
    sq_lane[0][1].mag  = ax_q[15] ? 16'(-ax_q) : ax_q;
    sq_lane[0][1].neg  = (ax_q > 16'sd0);
  end

  for (genvar k = 0; k < ata_pkg::SQRT_STEPS; k++) begin : g_sqrt
    for (genvar l = 0; l < 2; l++) begin : g_lane
      ata_sqrt_step u_step (
        .clk_i  (clk_i),
        .adv_i  (adv),
        .lane_i (sq_lane[k][l]),
        .lane_o (sq_lane[k+1][l])
      );
    end
  end

  // root is the Q.16 divisor, numerator moves to Q.16
  for (genvar l = 0; l < 2; l++) begin : g_seed
    always_comb begin
      cd_lane[0][l].x = {4'b0000, sq_lane[ata_pkg::SQRT_STEPS][l].root};
      cd_lane[0][l].y = {4'b0000, sq_lane[ata_pkg::SQRT_STEPS][l].mag, 16'h0000};
      cd_lane[0][l].z = '0;
      cd_lane[0][l].nz       = (sq_lane[ata_pkg::SQRT_STEPS][l].mag != '0);
      cd_lane[0][l].den_zero = (sq_lane[ata_pkg::SQRT_STEPS][l].root == '0);
      cd_lane[0][l].neg      = sq_lane[ata_pkg::SQRT_STEPS][l].neg;
    end
  end

  for (genvar j = 0; j < ata_pkg::CORDIC_STEPS; j++) begin : g_cordic
    for (genvar l = 0; l < 2; l++) begin : g_lane
      ata_cordic_step u_step (
        .clk_i   (clk_i),
        .adv_i   (adv),
        .shift_i (ata_pkg::TABLE_IDX_W'(j)),
        .lane_i  (cd_lane[j][l]),
        .lane_o  (cd_lane[j+1][l])
      );
    end
  end

  ata_angle_out u_roll (
    .lane_i  (cd_lane[ata_pkg::CORDIC_STEPS][0]),
    .angle_o (roll_d)
  );

  ata_angle_out u_pitch (
    .lane_i  (cd_lane[ata_pkg::CORDIC_STEPS][1]),
    .angle_o (pitch_d)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pipe_vld_q[TOT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      zero_q  <= pipe_zero_q[TOT];
    end
  end

  assign out_valid_o = out_valid_q;
  assign roll_deg_o  = roll_q;
  assign pitch_deg_o = pitch_q;
  assign all_zero_o  = zero_q;

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> pipe_vld_q[0])
    else $error("accepted request did not enter the pipeline");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(pipe_vld_q))
    else $error("pipeline moved during a stall");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && all_zero_o) |-> (roll_deg_o == 16'sd0 && pitch_deg_o == 16'sd0))
    else $error("all-zero sample with nonzero angle");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (roll_deg_o <= 16'(ata_pkg::CAP) && roll_deg_o >= -16'(ata_pkg::CAP)
                     && pitch_deg_o <= 16'(ata_pkg::CAP) && pitch_deg_o >= -16'(ata_pkg::CAP)))
    else $error("angle beyond 90 degrees");

endmodule

[tb/sv/accel_tilt_angles_core_tb.sv]
// Testbench for the accelerometer roll and pitch pipeline: directed and random samples.
`timescale 1ns / 100ps

module accel_tilt_angles_core_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 2 + ata_pkg::SQRT_STEPS + ata_pkg::CORDIC_STEPS + 10;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic               zero;
  } tilt_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] accel_x_i = '0;
  logic signed [15:0] accel_y_i = '0;
  logic signed [15:0] accel_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] roll_deg_o;
  logic signed [15:0] pitch_deg_o;
  logic               all_zero_o;

  tilt_t expected_angles[$];
  int    errors = 0;
  int    idle_cycles = 0;
  bit    stimulus_done = 1'b0;

  accel_tilt_angles_core dut (.*);

  always #2 clk_i = ~clk_i;

  // Integer square root, floor, of a 64-bit value.
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] rem, root, bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem && bitv != 0) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Signed angle of atan(num / sqrt(a^2 + b^2)) in Q.F degrees.
  function automatic logic signed [15:0] tilt_of(input longint num, input longint a,
                                                 input longint b);
    longint       x, y, acc, xs, ys, cap, lim;
    logic [63:0]  den;
    int           i;
    lim = longint'(90) << ata_pkg::TABLE_FRAC;
    den = floor_root((a * a + b * b) << 32);
    if (num == 0) return '0;
    if (den == 0) begin
      acc = lim;
    end else begin
      x = longint'(den);
      y = (num < 0 ? -num : num) << 16;
      acc = 0;
      for (i = 0; i < ata_pkg::CORDIC_STEPS; i++) begin
        xs = x >>> i;  // arithmetic shift floors
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs;
          acc += longint'(ata_pkg::atan_deg_q16(ata_pkg::TABLE_IDX_W'(i)));
        end else begin
          x = x - ys; y = y + xs;
          acc -= longint'(ata_pkg::atan_deg_q16(ata_pkg::TABLE_IDX_W'(i)));
        end
      end
      if (acc < 0) acc = 0;
      if (acc > lim) acc = lim;
    end
    acc = (acc + (longint'(1) << (ata_pkg::TABLE_FRAC - ata_pkg::ANGLE_FRAC_BITS - 1)))
          >>> (ata_pkg::TABLE_FRAC - ata_pkg::ANGLE_FRAC_BITS);
    cap = longint'(90) << ata_pkg::ANGLE_FRAC_BITS;
    if (cap > 32767) cap = 32767;
    if (acc > cap) acc = cap;
    return num < 0 ? 16'(-acc) : 16'(acc);
  endfunction

  function automatic tilt_t predict_tilt(input logic signed [15:0] ax,
                                         input logic signed [15:0] ay,
                                         input logic signed [15:0] az);
    tilt_t t;
    if (ax == 0 && ay == 0 && az == 0) begin
      t.roll = '0; t.pitch = '0; t.zero = 1'b1;
    end else begin
      t.roll  = tilt_of(longint'(ay), longint'(ax), longint'(az));
      t.pitch = tilt_of(-longint'(ax), longint'(ay), longint'(az));
      t.zero  = 1'b0;
    end
    return t;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Send one request and hold it until accepted; valid stays up for the next one.
  task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                             input logic signed [15:0] az, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i  <= ax;
    accel_y_i  <= ay;
    accel_z_i  <= az;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_angles.push_back(predict_tilt(ax, ay, az));
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'sh7fff;
      2: return 16'sh8000;
      3: return 16'($signed($urandom_range(0, 16)) - 8);
      4: return '0;
      default: return 16'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic test_directed();
    send_sample(0, 0, 0, 0);                          // all axes zero
    send_sample(16'sh7fff, 0, 0, 0);                  // roll divisor nonzero, zero numerator
    send_sample(0, 16'sh7fff, 0, 0);                  // roll divisor zero: +90
    send_sample(0, 16'sh8000, 0, 0);                  // roll divisor zero: -90
    send_sample(16'sh8000, 0, 0, 0);                  // pitch +90
    send_sample(0, 0, 16'sh7fff, 0);
    send_sample(0, 0, 16'sh8000, 0);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 0);
    send_sample(1, 1, 1, 0);
    send_sample(-1, -1, -1, 0);
    send_sample(1, 0, 0, 0);
    send_sample(0, -1, 0, 0);
    send_sample(16'sh5555, 16'shaaaa, 16'sh00ff, 0);
    send_sample(16'shaaaa, 16'sh5555, 16'shff00, 0);
    send_sample(0, 1, 16'sh7fff, 0);
    send_sample(16'sh7fff, 1, 0, 0);
  endtask

  task automatic test_random(input int count);
    repeat (count) begin
      send_sample(rand_axis(), rand_axis(), rand_axis(), 1);
    end
  endtask

  // Pause the sender until the pipeline has drained, then send 40 random samples.
  task automatic test_drain_pause();
    in_valid_i <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk_i);
    test_random(40);
  endtask

  // Back-to-back requests with no gaps.
  task automatic test_burst();
    repeat (200) send_sample(rand_axis(), rand_axis(), rand_axis(), 0);
  endtask

  // Random consumer stalls, with stretches of none.
  initial begin
    int g;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 9) < 3) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        g = gap_len();
        out_ready_i <= (g == 0);
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // Check each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    tilt_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result roll=%0d pitch=%0d zero=%0b", $time,
                 roll_deg_o, pitch_deg_o, all_zero_o);
        errors++;
      end else begin
        e = expected_angles.pop_front();
        if (roll_deg_o !== e.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, e.roll, roll_deg_o);
          errors++;
        end
        if (pitch_deg_o !== e.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch_deg_o);
          errors++;
        end
        if (all_zero_o !== e.zero) begin
          $display("%0t: all_zero expected %0b actual %0b", $time, e.zero, all_zero_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no request moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else if (!stimulus_done || expected_angles.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(700);
    test_drain_pause();
    test_burst();
    test_random(750);
    in_valid_i <= 1'b0;
    stimulus_done = 1'b1;
    while (expected_angles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/ata_pkg.sv
rtl/core/ata_sqrt_step.sv
rtl/core/ata_cordic_step.sv
rtl/core/ata_angle_out.sv
rtl/core/accel_tilt_angles_core.sv
tb/sv/accel_tilt_angles_core_tb.sv
